// File: hdl/fdr_pkg.sv
// shared types and constants of the flood relay duplicate filter
package fdr_pkg;

  // configuration port geometry
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register word index, taken from paddr[3:2]
  localparam logic [1:0] REG_MY_ID        = 2'd0;
  localparam logic [1:0] REG_BROADCAST_ID = 2'd1;
  localparam logic [1:0] REG_GROUP_LOW    = 2'd2;
  localparam logic [1:0] REG_GROUP_HIGH   = 2'd3;

  // register reset values
  localparam logic [15:0] MY_ID_RST        = 16'h0000;
  localparam logic [15:0] BROADCAST_ID_RST = 16'hFFFF;
  localparam logic [15:0] GROUP_LOW_RST    = 16'hFF00;
  localparam logic [15:0] GROUP_HIGH_RST   = 16'hFFFE;

  // received packet header
  typedef struct packed {
    logic [15:0] source_id;
    logic [15:0] dest_id;
    logic [15:0] sequence_req;
    logic [7:0]  hops_left;
  } req_t;

  // filter decision
  typedef struct packed {
    logic       deliver;
    logic       duplicate;
    logic       relay;
    logic [7:0] relay_hops;
  } rsp_t;

  // one entry of the seen-pair ring
  typedef struct packed {
    logic [15:0] source_id;
    logic [15:0] sequence_req;
  } entry_t;

endpackage

// File: hdl/flood_relay_dedup_filter_core.sv
// flood relay filter: duplicate ring lookup, delivery and relay decision
//
//  channel   signals                          transfer
//  --------  -------------------------------  --------------------------------
//  request   start, busy, req_i               start high while busy low
//  result    done_o, rsp_o                    done_o high for one cycle
//  config    psel, penable, pwrite, paddr,    access phase, pready always high
//            pwdata, prdata, pready
//
// after acceptance a packet header is checked against every ring entry: the
// ring memory is read one entry per cycle through its single read port, state
// S_LAST compares the last entry and writes a new pair at the ring head unless
// a match was seen, and done_o follows. busy is low again in the cycle done_o is shown.
// reset clears the per-entry valid bits at once, so no clearing pass is needed;
// an entry that is not valid reads as zero. the receiver cannot stall results.
module flood_relay_dedup_filter_core #(
  parameter int unsigned DEDUP_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  fdr_pkg::req_t              req_i,
  output logic                       done_o,
  output fdr_pkg::rsp_t              rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fdr_pkg::ADDR_W-1:0] paddr,
  input  logic [fdr_pkg::DATA_W-1:0] pwdata,
  output logic [fdr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned IDX_W = (DEDUP_DEPTH > 1) ? $clog2(DEDUP_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEDUP_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST
  } state_e;

  // configuration registers
  logic [15:0] my_id_q, broadcast_id_q, group_low_q, group_high_q;
  logic        cfg_we;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_id_q        <= fdr_pkg::MY_ID_RST;
      broadcast_id_q <= fdr_pkg::BROADCAST_ID_RST;
      group_low_q    <= fdr_pkg::GROUP_LOW_RST;
      group_high_q   <= fdr_pkg::GROUP_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fdr_pkg::REG_MY_ID:        my_id_q        <= pwdata[15:0];
        fdr_pkg::REG_BROADCAST_ID: broadcast_id_q <= pwdata[15:0];
        fdr_pkg::REG_GROUP_LOW:    group_low_q    <= pwdata[15:0];
        fdr_pkg::REG_GROUP_HIGH:   group_high_q   <= pwdata[15:0];
        default:                   ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      fdr_pkg::REG_MY_ID:        prdata = {16'h0000, my_id_q};
      fdr_pkg::REG_BROADCAST_ID: prdata = {16'h0000, broadcast_id_q};
      fdr_pkg::REG_GROUP_LOW:    prdata = {16'h0000, group_low_q};
      fdr_pkg::REG_GROUP_HIGH:   prdata = {16'h0000, group_high_q};
      default:                   prdata = '0;
    endcase
  end

  // control and datapath state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] rd_addr_q, rd_addr_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic             cmp_pend_q, cmp_pend_d;
  logic             hit_q, hit_d;
  logic             done_q, done_d;
  logic [DEDUP_DEPTH-1:0] valid_q, valid_d;
  fdr_pkg::req_t    item_q, item_d;
  fdr_pkg::rsp_t    rsp_q, rsp_d;

  // ring memory, one read port and one write port
  fdr_pkg::entry_t  mem_q [DEDUP_DEPTH];
  fdr_pkg::entry_t  rd_data_q;
  logic             rd_valid_q;
  logic             mem_we;
  fdr_pkg::entry_t  wr_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_q] <= wr_entry;
    end
    rd_data_q  <= mem_q[rd_addr_q];
    rd_valid_q <= valid_q[rd_addr_q];
  end

  // compare of the entry read in the previous cycle
  fdr_pkg::entry_t stored;
  logic            match;
  logic            hit_all;
  logic            for_me;
  logic            fwd;

  assign stored  = rd_valid_q ? rd_data_q : '0;
  assign match   = cmp_pend_q && (stored.source_id == item_q.source_id) &&
                   (stored.sequence_req == item_q.sequence_req);
  assign hit_all = hit_q | match;

  assign wr_entry.source_id    = item_q.source_id;
  assign wr_entry.sequence_req = item_q.sequence_req;

  // delivery and relay decision
  assign for_me = (item_q.dest_id == my_id_q) || (item_q.dest_id == broadcast_id_q) ||
                  ((item_q.dest_id >= group_low_q) && (item_q.dest_id <= group_high_q));
  assign fwd    = (item_q.hops_left != 8'd0) && (item_q.dest_id != my_id_q) &&
                  (item_q.source_id != my_id_q);

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    rd_addr_d  = rd_addr_q;
    head_d     = head_q;
    cmp_pend_d = 1'b0;
    hit_d      = hit_q;
    done_d     = 1'b0;
    valid_d    = valid_q;
    item_d     = item_q;
    rsp_d      = rsp_q;
    mem_we     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d    = req_i;
          rd_addr_d = '0;
          hit_d     = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_pend_d = 1'b1;
        hit_d      = hit_all;
        if (rd_addr_q == LAST_IDX) begin
          state_d = S_LAST;
        end else begin
          rd_addr_d = rd_addr_q + 1'b1;
        end
      end
      S_LAST: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        rsp_d   = '0;
        if (hit_all) begin
          rsp_d.duplicate = 1'b1;
        end else begin
          mem_we          = 1'b1;
          valid_d[head_q] = 1'b1;
          head_d          = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
          rsp_d.deliver   = for_me;
          rsp_d.relay     = fwd;
          rsp_d.relay_hops = fwd ? (item_q.hops_left - 8'd1) : 8'd0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_addr_q  <= '0;
      head_q     <= '0;
      cmp_pend_q <= 1'b0;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      rd_addr_q  <= rd_addr_d;
      head_q     <= head_d;
      cmp_pend_q <= cmp_pend_d;
      hit_q      <= hit_d;
      done_q     <= done_d;
      valid_q    <= valid_d;
    end
  end

  // transaction payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: hdl/fdr_checker.sv
// port-level checks of the flood relay filter and their binding
module fdr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input fdr_pkg::rsp_t rsp_o
);

  // result shows while the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result strobe is always low again after it is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // a duplicate is neither delivered nor relayed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.duplicate) |-> (!rsp_o.deliver && !rsp_o.relay))
    else $error("duplicate delivered or relayed");

  // hop count is zero without relay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.relay) |-> (rsp_o.relay_hops == 8'd0))
    else $error("relay hops nonzero without relay");

endmodule

bind flood_relay_dedup_filter_core fdr_checker u_fdr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// File: bench/tb_top.sv
// self-checking bench for the flood relay duplicate filter core
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RING_DEPTH  = 16;
  localparam int unsigned DRAIN_WAIT  = RING_DEPTH + 6;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PKTS = 800;
  localparam int unsigned HISTORY_LEN = 40;

  // dut signals, known from time zero
  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        start   = 1'b0;
  logic                        busy;
  fdr_pkg::req_t               req_i   = '0;
  logic                        done_o;
  fdr_pkg::rsp_t               rsp_o;
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [fdr_pkg::ADDR_W-1:0]  paddr   = '0;
  logic [fdr_pkg::DATA_W-1:0]  pwdata  = '0;
  logic [fdr_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  flood_relay_dedup_filter_core #(
    .DEDUP_DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow configuration
  logic [15:0] node_id;
  logic [15:0] bcast_id;
  logic [15:0] grp_low;
  logic [15:0] grp_high;

  // shadow duplicate ring
  logic [15:0] ring_src [RING_DEPTH];
  logic [15:0] ring_seq [RING_DEPTH];
  int unsigned ring_wr;

  // decisions awaiting the dut, and recently accepted pairs
  fdr_pkg::rsp_t   pending_decisions[$];
  fdr_pkg::entry_t recent_pairs[$];
  fdr_pkg::rsp_t   oldest;

  int unsigned idle_pct;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned pkt_count;
  int unsigned dup_count;
  int unsigned deliver_count;
  int unsigned relay_count;
  int unsigned cfg_writes;
  int unsigned cfg_reads;

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // filter decision for one accepted header, updating the shadow ring
  function automatic fdr_pkg::rsp_t filter_decide(fdr_pkg::req_t p);
    fdr_pkg::rsp_t r;
    bit            hit;
    r   = '0;
    hit = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (ring_src[i] == p.source_id && ring_seq[i] == p.sequence_req) hit = 1'b1;
    end
    if (hit) begin
      r.duplicate = 1'b1;
      dup_count++;
      return r;
    end
    ring_src[ring_wr] = p.source_id;
    ring_seq[ring_wr] = p.sequence_req;
    ring_wr = (ring_wr + 1) % RING_DEPTH;
    r.deliver = (p.dest_id == node_id) || (p.dest_id == bcast_id) ||
                (p.dest_id >= grp_low && p.dest_id <= grp_high);
    if (p.hops_left != 8'd0 && p.dest_id != node_id && p.source_id != node_id) begin
      r.relay      = 1'b1;
      r.relay_hops = p.hops_left - 8'd1;
    end
    if (r.deliver) deliver_count++;
    if (r.relay) relay_count++;
    return r;
  endfunction

  // result checker: each strobe against the oldest pending decision
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_decisions.size() == 0) begin
        $error("result transaction with no packet pending");
        fail_count++;
      end else begin
        oldest = pending_decisions.pop_front();
        if (rsp_o.deliver !== oldest.deliver) begin
          $error("deliver: expected %0b, got %0b", oldest.deliver, rsp_o.deliver);
          fail_count++;
        end
        if (rsp_o.duplicate !== oldest.duplicate) begin
          $error("duplicate: expected %0b, got %0b", oldest.duplicate, rsp_o.duplicate);
          fail_count++;
        end
        if (rsp_o.relay !== oldest.relay) begin
          $error("relay: expected %0b, got %0b", oldest.relay, rsp_o.relay);
          fail_count++;
        end
        if (rsp_o.relay_hops !== oldest.relay_hops) begin
          $error("relay_hops: expected %0d, got %0d", oldest.relay_hops, rsp_o.relay_hops);
          fail_count++;
        end
      end
    end
  end

  // send one header; returns at the edge that accepted it, or after the idle gap
  task automatic send_packet(input fdr_pkg::req_t p);
    int unsigned gap;
    start <= 1'b1;
    req_i <= p;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_decisions.push_back(filter_decide(p));
    recent_pairs.push_back('{source_id: p.source_id, sequence_req: p.sequence_req});
    if (recent_pairs.size() > HISTORY_LEN) void'(recent_pairs.pop_front());
    pkt_count++;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 24) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_header(input logic [15:0] src, input logic [15:0] dst,
                             input logic [15:0] seq, input logic [7:0] hops);
    fdr_pkg::req_t p;
    p.source_id    = src;
    p.dest_id      = dst;
    p.sequence_req = seq;
    p.hops_left    = hops;
    send_packet(p);
  endtask

  // let every pending decision come back before touching registers
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_decisions.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // one apb transaction: setup cycle, then access until pready
  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [15:0] val,
                          output logic [fdr_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(fdr_pkg::DATA_W-16){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    logic [fdr_pkg::DATA_W-1:0] unused;
    apb_xfer(1'b1, idx, val, unused);
    case (idx)
      fdr_pkg::REG_MY_ID:        node_id  = val;
      fdr_pkg::REG_BROADCAST_ID: bcast_id = val;
      fdr_pkg::REG_GROUP_LOW:    grp_low  = val;
      fdr_pkg::REG_GROUP_HIGH:   grp_high = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic reg_expect(input logic [1:0] idx);
    logic [fdr_pkg::DATA_W-1:0] got;
    logic [15:0]                want;
    apb_xfer(1'b0, idx, 16'h0000, got);
    case (idx)
      fdr_pkg::REG_MY_ID:        want = node_id;
      fdr_pkg::REG_BROADCAST_ID: want = bcast_id;
      fdr_pkg::REG_GROUP_LOW:    want = grp_low;
      default:                   want = grp_high;
    endcase
    if (got[15:0] !== want) begin
      $error("prdata reg %0d: expected %04h, got %04h", idx, want, got[15:0]);
      fail_count++;
    end
    cfg_reads++;
  endtask

  task automatic apply_config(input logic [15:0] me, input logic [15:0] bc,
                              input logic [15:0] lo, input logic [15:0] hi);
    reg_write(fdr_pkg::REG_MY_ID, me);
    reg_write(fdr_pkg::REG_BROADCAST_ID, bc);
    reg_write(fdr_pkg::REG_GROUP_LOW, lo);
    reg_write(fdr_pkg::REG_GROUP_HIGH, hi);
    reg_expect(fdr_pkg::REG_MY_ID);
    reg_expect(fdr_pkg::REG_BROADCAST_ID);
    reg_expect(fdr_pkg::REG_GROUP_LOW);
    reg_expect(fdr_pkg::REG_GROUP_HIGH);
  endtask

  // random header biased toward repeats, own id and group edges
  function automatic fdr_pkg::req_t random_packet();
    fdr_pkg::req_t   p;
    fdr_pkg::entry_t e;
    int unsigned     pick;
    p.source_id    = 16'($urandom);
    p.sequence_req = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35 && recent_pairs.size() != 0) begin
      e = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
      p.source_id    = e.source_id;
      p.sequence_req = e.sequence_req;
    end else if (pick < 45) begin
      p.source_id    = 16'($urandom_range(0, 3));
      p.sequence_req = 16'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 9) == 0) p.source_id = node_id;
    case ($urandom_range(0, 7))
      0:       p.dest_id = node_id;
      1:       p.dest_id = bcast_id;
      2:       p.dest_id = grp_low;
      3:       p.dest_id = grp_high;
      4:       p.dest_id = grp_low - 16'd1;
      5:       p.dest_id = grp_high + 16'd1;
      default: p.dest_id = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       p.hops_left = 8'd0;
      1:       p.hops_left = 8'd1;
      2:       p.hops_left = 8'hFF;
      default: p.hops_left = 8'($urandom);
    endcase
    return p;
  endfunction

  // reset values readable, zero pair seen as duplicate, basic decisions
  task automatic test_reset_state();
    reg_expect(fdr_pkg::REG_MY_ID);
    reg_expect(fdr_pkg::REG_BROADCAST_ID);
    reg_expect(fdr_pkg::REG_GROUP_LOW);
    reg_expect(fdr_pkg::REG_GROUP_HIGH);
    send_header(16'h0000, 16'h1234, 16'h0000, 8'd5);  // zero pair after reset
    send_header(16'h0001, 16'h0000, 16'h0000, 8'd3);  // to this node, no relay
    send_header(16'h0000, 16'h0005, 16'h0001, 8'd3);  // from this node, no relay
    send_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF); // broadcast, max hops
    send_header(16'h0002, 16'hFF00, 16'h0001, 8'd1);  // group low edge, last hop
    send_header(16'h0002, 16'hFFFE, 16'h0002, 8'd0);  // group high edge, hops spent
    send_header(16'h0002, 16'hFEFF, 16'h0003, 8'd9);  // just below group
    send_header(16'hFFFF, 16'h1111, 16'hFFFF, 8'd7);  // repeat pair, dropped
    wait_idle();
  endtask

  // empty group range and eviction from the ring
  task automatic test_group_and_eviction();
    apply_config(16'h00AA, 16'h0001, 16'h8000, 16'h7FFF);
    send_header(16'h0003, 16'h7FFF, 16'h0000, 8'd4);
    send_header(16'h0003, 16'h8000, 16'h0001, 8'd4);
    send_header(16'h0003, 16'h0001, 16'h0002, 8'd4);
    send_header(16'h0004, 16'h00AA, 16'h5555, 8'd4);
    for (int i = 0; i < RING_DEPTH; i++) begin
      send_header(16'h0100 + i[15:0], 16'h4000, 16'hAAAA, 8'd2);
    end
    send_header(16'h0001, 16'h0000, 16'h0000, 8'd3);  // pair evicted, new again
    send_header(16'h010F, 16'h4000, 16'hAAAA, 8'd2);  // still held, dropped
    wait_idle();
  endtask

  // random headers over several settings and idle patterns
  task automatic test_random_traffic();
    logic [15:0] lo;
    logic [15:0] hi;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          apply_config(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        end
        1: begin
          idle_pct = 47;
          lo = 16'($urandom);
          hi = 16'($urandom);
          if (lo > hi) apply_config(16'($urandom), 16'($urandom), hi, lo);
          else apply_config(16'($urandom), 16'($urandom), lo, hi);
        end
        2: begin
          idle_pct = 24;
          lo = 16'($urandom);
          apply_config(16'($urandom_range(0, 3)), 16'hFFFF, lo, lo);
        end
        default: begin
          idle_pct = 0;
          apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
      endcase
      for (int n = 0; n < RANDOM_PKTS / 4; n++) send_packet(random_packet());
      wait_idle();
    end
  endtask

  // stimulus
  initial begin
    node_id  = fdr_pkg::MY_ID_RST;
    bcast_id = fdr_pkg::BROADCAST_ID_RST;
    grp_low  = fdr_pkg::GROUP_LOW_RST;
    grp_high = fdr_pkg::GROUP_HIGH_RST;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_src[i] = '0;
      ring_seq[i] = '0;
    end
    ring_wr  = 0;
    idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_group_and_eviction();
    test_random_traffic();

    // drain, then allow for any stray strobe
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("checked %0d headers: %0d duplicates, %0d delivered, %0d relayed",
             pkt_count, dup_count, deliver_count, relay_count);
    $display("%0d register writes and %0d read-backs across 5 settings",
             cfg_writes, cfg_reads);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/fdr_pkg.sv
hdl/flood_relay_dedup_filter_core.sv
hdl/fdr_checker.sv
bench/tb_top.sv
